FILE: rtl/drsd_pkg.sv
// drsd_pkg: shared types and constants of the drrip replacement controller
// holds the item kind codes, back end states and the item and result records
// depends on nothing
`timescale 1ns / 1ps

package drsd_pkg;

  // fixed field widths of the item and result ports
  localparam int KIND_W  = 2;
  localparam int SET_W   = 11;
  localparam int WAY_W   = 4;
  localparam int ADDR_W  = 64;
  localparam int MASK_W  = 16;
  localparam int COIN_W  = 5;
  localparam int PSEL_W  = 10;
  localparam int RRPV_W  = 2;
  localparam int CNT_W   = 2;

  // the smallest set count is 2**6, so a set field reduces in this many steps
  localparam int SET_MOD_STEPS = SET_W - 6;

  // queue depths between the parts
  localparam int IN_DEPTH  = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

  // rrpv codes
  localparam logic [RRPV_W-1:0] RRPV_HIT  = 2'd0;
  localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd2;
  localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;

  // stream counter codes
  localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;
  localparam logic [CNT_W-1:0] CNT_ON  = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_VICTIM = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_DECAY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2,
    ST_DECAY = 2'd3
  } state_e;

  // classified item handed from the front to the back
  typedef struct packed {
    kind_e              kind;
    logic [SET_W-1:0]   set_idx;
    logic [WAY_W-1:0]   way;
    logic               way_ok;
    logic               hit;
    logic [ADDR_W-1:0]  addr;
    logic               coin_zero;
    logic               srrip_lead;
    logic               brrip_lead;
    logic               has_inv;
    logic [WAY_W-1:0]   inv_way;
  } item_t;

  // result item
  typedef struct packed {
    logic [WAY_W-1:0]   victim_way;
    logic [RRPV_W-1:0]  inserted_rrpv;
    logic               streaming;
    logic [PSEL_W-1:0]  psel_value;
  } result_t;

endpackage

FILE: rtl/drsd_fifo.sv
// drsd_fifo: small register queue used between the parts of the controller
// depends on nothing
`timescale 1ns / 1ps

module drsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   level_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int LvlW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [LvlW-1:0] LvlFull = LvlW'(DEPTH);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == LvlFull);
  assign empty_o = (count_q == '0);
  assign level_o = count_q;
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/drsd_front.sv
// drsd_front: accepts items, reduces the set index, classifies leader sets
// and finds the first invalid way, then queues the item for the back end
// depends on drsd_pkg and drsd_fifo
`timescale 1ns / 1ps

module drsd_front #(
  parameter int NUM_SETS    = 2048,
  parameter int NUM_WAYS    = 16,
  parameter int LEADER_SETS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [drsd_pkg::KIND_W-1:0]  kind_i,
  input  logic [drsd_pkg::SET_W-1:0]   set_index_i,
  input  logic [drsd_pkg::WAY_W-1:0]   way_index_i,
  input  logic                         is_hit_i,
  input  logic [drsd_pkg::ADDR_W-1:0]  address_i,
  input  logic [drsd_pkg::MASK_W-1:0]  valid_mask_i,
  input  logic [drsd_pkg::COIN_W-1:0]  coin_i,
  output drsd_pkg::item_t              item_o,
  output logic                         item_empty_o,
  input  logic                         item_pop_i
);

  localparam int MaskWays = (NUM_WAYS < drsd_pkg::MASK_W) ? NUM_WAYS : drsd_pkg::MASK_W;
  localparam int ItemW    = $bits(drsd_pkg::item_t);

  drsd_pkg::item_t               item;
  logic [drsd_pkg::SET_W-1:0]    set_red;
  logic [ItemW-1:0]              head;

  // set index modulo the set count by restoring subtraction
  always_comb begin
    set_red = set_index_i;
    for (int k = drsd_pkg::SET_MOD_STEPS - 1; k >= 0; k--) begin
      if (int'(set_red) >= (NUM_SETS << k)) begin
        set_red = set_red - drsd_pkg::SET_W'(NUM_SETS << k);
      end
    end
  end

  // classification of the incoming item
  always_comb begin
    item            = '0;
    item.kind       = drsd_pkg::kind_e'(kind_i);
    item.set_idx    = set_red;
    item.way        = way_index_i;
    item.way_ok     = int'(way_index_i) < NUM_WAYS;
    item.hit        = is_hit_i;
    item.addr       = address_i;
    item.coin_zero  = (coin_i == '0);
    item.srrip_lead = int'(set_red) < (LEADER_SETS / 2);
    item.brrip_lead = !item.srrip_lead && (int'(set_red) < LEADER_SETS);
    // lowest way without a valid bit set
    for (int w = MaskWays - 1; w >= 0; w--) begin
      if (!valid_mask_i[w]) begin
        item.has_inv = 1'b1;
        item.inv_way = drsd_pkg::WAY_W'(w);
      end
    end
  end

  // queue towards the back end
  drsd_fifo #(
    .WIDTH (ItemW),
    .DEPTH (drsd_pkg::IN_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item),
    .full_o  (full),
    .pop_i   (item_pop_i),
    .data_o  (head),
    .empty_o (item_empty_o),
    .level_o ()
  );

  assign item_o = drsd_pkg::item_t'(head);

endmodule

FILE: rtl/drsd_back.sv
// drsd_back: carries out queued items against the per-set rrpv, stride and
// stream counter memories and the shared policy selector
// depends on drsd_pkg
`timescale 1ns / 1ps

module drsd_back #(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int SELECTOR_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  drsd_pkg::item_t                item_i,
  input  logic                           item_empty_i,
  output logic                           item_pop_o,
  output drsd_pkg::result_t              res_o,
  output logic                           res_push_o,
  input  logic [drsd_pkg::OUT_LVL_W-1:0] res_level_i
);

  localparam int SW     = $clog2(NUM_SETS);
  localparam int RW     = drsd_pkg::RRPV_W;
  localparam int ROW_W  = NUM_WAYS * RW;
  localparam int AW     = drsd_pkg::ADDR_W;
  localparam int HIST_W = 2 * AW;
  localparam logic [SW:0] SetCount = (SW + 1)'(NUM_SETS);
  localparam logic [SW:0] SetLast  = (SW + 1)'(NUM_SETS - 1);
  localparam logic [SELECTOR_BITS-1:0] SelMax = '1;
  localparam logic [drsd_pkg::OUT_LVL_W-1:0] LvlStart = drsd_pkg::OUT_LVL_W'(drsd_pkg::OUT_DEPTH);
  localparam logic [drsd_pkg::OUT_LVL_W-1:0] LvlChain =
    drsd_pkg::OUT_LVL_W'(drsd_pkg::OUT_DEPTH - 1);

  // memories
  logic [ROW_W-1:0]           rrpv_mem [NUM_SETS];
  logic [HIST_W-1:0]          hist_mem [NUM_SETS];
  logic [drsd_pkg::CNT_W-1:0] cnt_mem  [NUM_SETS];

  logic [ROW_W-1:0]           row_rd_q;
  logic [HIST_W-1:0]          hist_rd_q;
  logic [drsd_pkg::CNT_W-1:0] cnt_rd_q;

  logic                       main_rd, cnt_rd, main_we, cnt_we;
  logic [SW-1:0]              rd_addr, main_wa, cnt_wa;
  logic [ROW_W-1:0]           row_wd;
  logic [HIST_W-1:0]          hist_wd;
  logic [drsd_pkg::CNT_W-1:0] cnt_wd;

  // control and item registers
  drsd_pkg::state_e           state_q, state_d;
  logic [SW:0]                idx_q, idx_d;
  logic                       wr_pend_q, wr_pend_d;
  logic [SW-1:0]              wr_idx_q, wr_idx_d;
  logic                       fwd_q, fwd_d;
  logic [SELECTOR_BITS-1:0]   psel_q, psel_d;
  drsd_pkg::item_t            item_q, item_d;
  logic [ROW_W-1:0]           fwd_row_q, fwd_row_d;
  logic [HIST_W-1:0]          fwd_hist_q, fwd_hist_d;
  logic [drsd_pkg::CNT_W-1:0] fwd_cnt_q, fwd_cnt_d;
  logic                       strm_q, strm_d;

  // execute datapath
  logic [SW-1:0]              cur_set, next_set;
  logic [ROW_W-1:0]           row, row_aged, row_upd, row_new;
  logic [HIST_W-1:0]          hist, hist_new;
  logic [drsd_pkg::CNT_W-1:0] cnt, cnt_upd, cnt_new, cnt_dec;
  logic [AW-1:0]              prev_addr, prev_delta, delta;
  logic                       any3, any2, any1, stride_match;
  logic [RW-1:0]              top, add, ins, brrip_val;
  logic [drsd_pkg::WAY_W-1:0] first3, victim;
  logic [SELECTOR_BITS-1:0]   psel_upd;
  drsd_pkg::result_t          exec_res;

  assign cur_set  = SW'(item_q.set_idx);
  assign next_set = SW'(item_i.set_idx);
  assign row      = fwd_q ? fwd_row_q : row_rd_q;
  assign hist     = fwd_q ? fwd_hist_q : hist_rd_q;
  assign cnt      = fwd_q ? fwd_cnt_q : cnt_rd_q;
  assign prev_addr  = hist[HIST_W-1:AW];
  assign prev_delta = hist[AW-1:0];

  // victim search: age the whole row so its largest rrpv reaches the maximum
  always_comb begin
    any3 = 1'b0;
    any2 = 1'b0;
    any1 = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (row[w*RW +: RW] == 2'd3);
      any2 = any2 | (row[w*RW +: RW] == 2'd2);
      any1 = any1 | (row[w*RW +: RW] == 2'd1);
    end
    top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
    add = drsd_pkg::RRPV_MAX - top;
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_aged[w*RW +: RW] = row[w*RW +: RW] + add;
    end
    first3 = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row_aged[w*RW +: RW] == drsd_pkg::RRPV_MAX) begin
        first3 = drsd_pkg::WAY_W'(w);
      end
    end
    victim = item_q.has_inv ? item_q.inv_way : first3;
  end

  // access update: stride detector, insertion depth and selector
  always_comb begin
    delta        = item_q.addr - prev_addr;
    stride_match = (prev_addr != '0) && (delta == prev_delta);
    if (stride_match) begin
      cnt_upd = (cnt == drsd_pkg::CNT_MAX) ? cnt : cnt + 1'b1;
    end else begin
      cnt_upd = (cnt == '0) ? cnt : cnt - 1'b1;
    end
    brrip_val = item_q.coin_zero ? drsd_pkg::RRPV_NEAR : drsd_pkg::RRPV_MAX;
    psel_upd  = psel_q;
    if (item_q.hit) begin
      ins = drsd_pkg::RRPV_HIT;
      if (item_q.srrip_lead && psel_q != SelMax) begin
        psel_upd = psel_q + 1'b1;
      end
      if (item_q.brrip_lead && psel_q != '0) begin
        psel_upd = psel_q - 1'b1;
      end
    end else if (cnt_upd >= drsd_pkg::CNT_ON) begin
      ins = drsd_pkg::RRPV_MAX;
    end else if (item_q.srrip_lead) begin
      ins = drsd_pkg::RRPV_NEAR;
    end else if (item_q.brrip_lead) begin
      ins = brrip_val;
    end else begin
      ins = psel_q[SELECTOR_BITS-1] ? drsd_pkg::RRPV_NEAR : brrip_val;
    end
    row_upd = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (item_q.way_ok && int'(item_q.way) == w) begin
        row_upd[w*RW +: RW] = ins;
      end
    end
  end

  // per-kind selection of written values and the result
  always_comb begin
    row_new  = row;
    hist_new = hist;
    cnt_new  = cnt;
    psel_d   = psel_q;
    exec_res = '0;
    case (item_q.kind)
      drsd_pkg::KIND_VICTIM: begin
        if (!item_q.has_inv) begin
          row_new = row_aged;
        end
        exec_res.victim_way = victim;
      end
      drsd_pkg::KIND_UPDATE: begin
        row_new  = row_upd;
        hist_new = {item_q.addr, delta};
        cnt_new  = cnt_upd;
        psel_d   = psel_upd;
        exec_res.inserted_rrpv = ins;
      end
      default: begin
      end
    endcase
    exec_res.streaming  = (cnt_new >= drsd_pkg::CNT_ON);
    exec_res.psel_value = drsd_pkg::PSEL_W'(psel_d);
  end

  assign cnt_dec = (cnt_rd_q == '0) ? cnt_rd_q : cnt_rd_q - 1'b1;

  // sequencer: clearing pass, item execution and decay sweep
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    wr_pend_d  = wr_pend_q;
    wr_idx_d   = wr_idx_q;
    fwd_d      = fwd_q;
    item_d     = item_q;
    fwd_row_d  = fwd_row_q;
    fwd_hist_d = fwd_hist_q;
    fwd_cnt_d  = fwd_cnt_q;
    strm_d     = strm_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o      = exec_res;
    main_rd    = 1'b0;
    cnt_rd     = 1'b0;
    rd_addr    = next_set;
    main_we    = 1'b0;
    main_wa    = cur_set;
    row_wd     = row_new;
    hist_wd    = hist_new;
    cnt_we     = 1'b0;
    cnt_wa     = cur_set;
    cnt_wd     = cnt_new;
    case (state_q)
      drsd_pkg::ST_CLEAR: begin
        main_we = 1'b1;
        cnt_we  = 1'b1;
        main_wa = idx_q[SW-1:0];
        cnt_wa  = idx_q[SW-1:0];
        row_wd  = '1;
        hist_wd = '0;
        cnt_wd  = '0;
        if (idx_q == SetLast) begin
          idx_d   = '0;
          state_d = drsd_pkg::ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      drsd_pkg::ST_IDLE: begin
        fwd_d = 1'b0;
        if (!item_empty_i && res_level_i < LvlStart) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          if (item_i.kind == drsd_pkg::KIND_DECAY) begin
            idx_d     = '0;
            wr_pend_d = 1'b0;
            state_d   = drsd_pkg::ST_DECAY;
          end else begin
            main_rd = 1'b1;
            cnt_rd  = 1'b1;
            state_d = drsd_pkg::ST_EXEC;
          end
        end
      end
      drsd_pkg::ST_EXEC: begin
        main_we    = 1'b1;
        cnt_we     = 1'b1;
        res_push_o = 1'b1;
        fwd_row_d  = row_new;
        fwd_hist_d = hist_new;
        fwd_cnt_d  = cnt_new;
        // start the next item at once when it reads a set row
        if (!item_empty_i && res_level_i < LvlChain &&
            item_i.kind != drsd_pkg::KIND_DECAY) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          main_rd    = 1'b1;
          cnt_rd     = 1'b1;
          fwd_d      = (next_set == cur_set);
        end else begin
          fwd_d   = 1'b0;
          state_d = drsd_pkg::ST_IDLE;
        end
      end
      drsd_pkg::ST_DECAY: begin
        // read one counter a cycle, write it back decremented the next
        if (idx_q != SetCount) begin
          cnt_rd    = 1'b1;
          rd_addr   = idx_q[SW-1:0];
          idx_d     = idx_q + 1'b1;
          wr_pend_d = 1'b1;
          wr_idx_d  = idx_q[SW-1:0];
        end else begin
          wr_pend_d = 1'b0;
        end
        res_o            = '0;
        res_o.psel_value = drsd_pkg::PSEL_W'(psel_q);
        res_o.streaming  = strm_q;
        if (wr_pend_q) begin
          cnt_we = 1'b1;
          cnt_wa = wr_idx_q;
          cnt_wd = cnt_dec;
          if (wr_idx_q == cur_set) begin
            strm_d          = (cnt_dec >= drsd_pkg::CNT_ON);
            res_o.streaming = (cnt_dec >= drsd_pkg::CNT_ON);
          end
          if (idx_q == SetCount) begin
            res_push_o = 1'b1;
            idx_d      = '0;
            state_d    = drsd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = drsd_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= drsd_pkg::ST_CLEAR;
      idx_q     <= '0;
      wr_pend_q <= 1'b0;
      fwd_q     <= 1'b0;
      psel_q    <= {1'b1, {(SELECTOR_BITS-1){1'b0}}};
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      wr_pend_q <= wr_pend_d;
      fwd_q     <= fwd_d;
      psel_q    <= (state_q == drsd_pkg::ST_EXEC) ? psel_d : psel_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    wr_idx_q   <= wr_idx_d;
    fwd_row_q  <= fwd_row_d;
    fwd_hist_q <= fwd_hist_d;
    fwd_cnt_q  <= fwd_cnt_d;
    strm_q     <= strm_d;
  end

  // rrpv rows and stride history
  always_ff @(posedge clk_i) begin
    if (main_we) begin
      rrpv_mem[main_wa] <= row_wd;
      hist_mem[main_wa] <= hist_wd;
    end
    if (main_rd) begin
      row_rd_q  <= rrpv_mem[rd_addr];
      hist_rd_q <= hist_mem[rd_addr];
    end
  end

  // stream counters
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_rd) begin
      cnt_rd_q <= cnt_mem[rd_addr];
    end
  end

endmodule

FILE: rtl/drrip_replacement_with_stream_detect.sv
// drrip_replacement_with_stream_detect: last-level cache replacement controller
// with set dueling and a per-set stream detector
// depends on drsd_pkg, drsd_front, drsd_back and drsd_fifo
//
// usage
//   items enter through a queue port: an item is taken on a clock edge with
//   push high and full low. results leave through a queue port: the oldest
//   result sits on the result ports while empty is low and is taken on an
//   edge with pop high. every item gives exactly one result, in order.
//   a victim request or access update is popped into the execute state, where
//   its result is pushed; back to back such items go through at one per cycle
//   while the output queue holds under three results, since the next set row is
//   read while the current one is written back (same-set rows are forwarded).
//   a decay item walks every stream counter, one set per cycle on the counter
//   memory port.
//   after reset a clearing pass writes every set row; up to two items queue
//   meanwhile and full stays high after that.
//   when the receiver stalls, results gather in a four-entry output queue,
//   then the back end halts and the input queue fills and raises full.
`timescale 1ns / 1ps

module drrip_replacement_with_stream_detect #(
  parameter int NUM_SETS      = 2048,
  parameter int NUM_WAYS      = 16,
  parameter int LEADER_SETS   = 64,
  parameter int SELECTOR_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [drsd_pkg::KIND_W-1:0]  kind_i,
  input  logic [drsd_pkg::SET_W-1:0]   set_index_i,
  input  logic [drsd_pkg::WAY_W-1:0]   way_index_i,
  input  logic                         is_hit_i,
  input  logic [drsd_pkg::ADDR_W-1:0]  address_i,
  input  logic [drsd_pkg::MASK_W-1:0]  valid_mask_i,
  input  logic [drsd_pkg::COIN_W-1:0]  coin_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [drsd_pkg::WAY_W-1:0]   victim_way_o,
  output logic [drsd_pkg::RRPV_W-1:0]  inserted_rrpv_o,
  output logic                         streaming_o,
  output logic [drsd_pkg::PSEL_W-1:0]  psel_value_o
);

  localparam int ResW = $bits(drsd_pkg::result_t);

  drsd_pkg::item_t                 item;
  logic                            item_empty, item_pop;
  drsd_pkg::result_t               res, res_head;
  logic                            res_push;
  logic [drsd_pkg::OUT_LVL_W-1:0]  res_level;
  logic [ResW-1:0]                 res_bits;

  // front: accept and classify
  drsd_front #(
    .NUM_SETS    (NUM_SETS),
    .NUM_WAYS    (NUM_WAYS),
    .LEADER_SETS (LEADER_SETS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .kind_i       (kind_i),
    .set_index_i  (set_index_i),
    .way_index_i  (way_index_i),
    .is_hit_i     (is_hit_i),
    .address_i    (address_i),
    .valid_mask_i (valid_mask_i),
    .coin_i       (coin_i),
    .item_o       (item),
    .item_empty_o (item_empty),
    .item_pop_i   (item_pop)
  );

  // back: execute against the set memories
  drsd_back #(
    .NUM_SETS      (NUM_SETS),
    .NUM_WAYS      (NUM_WAYS),
    .SELECTOR_BITS (SELECTOR_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .res_o        (res),
    .res_push_o   (res_push),
    .res_level_i  (res_level)
  );

  // result queue
  drsd_fifo #(
    .WIDTH (ResW),
    .DEPTH (drsd_pkg::OUT_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (res_bits),
    .empty_o (empty),
    .level_o (res_level)
  );

  assign res_head        = drsd_pkg::result_t'(res_bits);
  assign victim_way_o    = res_head.victim_way;
  assign inserted_rrpv_o = res_head.inserted_rrpv;
  assign streaming_o     = res_head.streaming;
  assign psel_value_o    = res_head.psel_value;

endmodule
